// ===== hdl/ufold_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufold_pkg
// Shared types, constants and the fold table of the UTF-8 accent fold stream.
// ----------------------------------------------------------------------------
package ufold_pkg;

    localparam int MAX_BURST = 6;
    localparam int HELD_DEPTH = 3;

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF4;
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;
    localparam logic [7:0] LATIN1_LEAD = 8'hC3;
    localparam logic [7:0] E0_CONT_LO  = 8'hA0;
    localparam logic [7:0] ED_CONT_HI  = 8'h9F;
    localparam logic [7:0] F0_CONT_LO  = 8'h90;
    localparam logic [7:0] F4_CONT_HI  = 8'h8F;

    localparam logic [7:0] FOLD_ROM [64] = '{
        8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h43,
        8'h45, 8'h45, 8'h45, 8'h45, 8'h49, 8'h49, 8'h49, 8'h49,
        8'h44, 8'h4E, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h00,
        8'h4F, 8'h55, 8'h55, 8'h55, 8'h55, 8'h59, 8'h00, 8'h00,
        8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h63,
        8'h65, 8'h65, 8'h65, 8'h65, 8'h69, 8'h69, 8'h69, 8'h69,
        8'h64, 8'h6E, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h00,
        8'h6F, 8'h75, 8'h75, 8'h75, 8'h75, 8'h79, 8'h00, 8'h79
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       word_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_word_end;
        logic       run_end;
    } out_item_t;

    typedef struct packed {
        logic [HELD_DEPTH-1:0][7:0] bytes;
        logic [1:0]                 count;
        logic [2:0]                 exp_len;
    } held_t;

    typedef struct packed {
        logic [MAX_BURST-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      word_end;
    } burst_t;

endpackage

// ===== hdl/ufold_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufold_decode
// Decodes one held item against the partial sequence state and builds the
// burst of output bytes plus the next sequence state.
// ----------------------------------------------------------------------------
module ufold_decode
(
    input  ufold_pkg::in_item_t item,
    input  logic                fold_enable,
    input  ufold_pkg::held_t    held,
    output ufold_pkg::burst_t   burst,
    output ufold_pkg::held_t    held_next
);

    always_comb
    begin : decode_proc
        logic [7:0]                           b;
        logic [ufold_pkg::MAX_BURST-1:0][7:0] lst;
        logic [2:0]                           n;
        logic [ufold_pkg::HELD_DEPTH-1:0][7:0] hb;
        logic [1:0]                           hc;
        logic [2:0]                           el;
        logic [7:0]                           lo;
        logic [7:0]                           hi;
        logic                                 restart;
        logic                                 cont;
        logic                                 do_start;

        b        = item.in_byte;
        lst      = '0;
        n        = 3'd0;
        hb       = held.bytes;
        hc       = held.count;
        el       = held.exp_len;
        lo       = ufold_pkg::CONT_LO;
        hi       = ufold_pkg::CONT_HI;
        restart  = 1'b0;
        cont     = 1'b0;
        do_start = 1'b0;

        if (!fold_enable)
        begin
            lst[0] = b;
            n      = 3'd1;
        end
        else
        begin
            restart = (hc == 2'd0) || (el < 3'd2) || (el > 3'd4);
            if (hc == 2'd1)
            begin
                priority if (hb[0] == ufold_pkg::LEAD_E0)
                begin
                    lo = ufold_pkg::E0_CONT_LO;
                end
                else if (hb[0] == ufold_pkg::LEAD_ED)
                begin
                    hi = ufold_pkg::ED_CONT_HI;
                end
                else if (hb[0] == ufold_pkg::LEAD_F0)
                begin
                    lo = ufold_pkg::F0_CONT_LO;
                end
                else if (hb[0] == ufold_pkg::LEAD_F4)
                begin
                    hi = ufold_pkg::F4_CONT_HI;
                end
                else
                begin
                    lo = ufold_pkg::CONT_LO;
                end
            end
            cont = (b >= lo) && (b <= hi);

            priority if (restart)
            begin
                hc       = 2'd0;
                el       = 3'd0;
                do_start = 1'b1;
            end
            else if (cont)
            begin
                if (({1'b0, hc} + 3'd1) == el)
                begin
                    // complete the code point: fold or re-emit
                    if ((el == 3'd2) && (hb[0] == ufold_pkg::LATIN1_LEAD) &&
                        (ufold_pkg::FOLD_ROM[b[5:0]] != 8'h00))
                    begin
                        lst[n] = ufold_pkg::FOLD_ROM[b[5:0]];
                        n      = n + 3'd1;
                    end
                    else
                    begin
                        for (int i = 0; i < ufold_pkg::HELD_DEPTH; i++)
                        begin
                            if (i < int'(hc))
                            begin
                                lst[n] = hb[i];
                                n      = n + 3'd1;
                            end
                        end
                        lst[n] = b;
                        n      = n + 3'd1;
                    end
                    hc = 2'd0;
                    el = 3'd0;
                end
                else
                begin
                    hb[hc] = b;
                    hc     = hc + 2'd1;
                end
            end
            else
            begin
                // drop the broken prefix, then restart on this byte
                lst[n] = ufold_pkg::REPL_B0;
                n      = n + 3'd1;
                lst[n] = ufold_pkg::REPL_B1;
                n      = n + 3'd1;
                lst[n] = ufold_pkg::REPL_B2;
                n      = n + 3'd1;
                hc       = 2'd0;
                el       = 3'd0;
                do_start = 1'b1;
            end

            if (do_start)
            begin
                priority if (b < ufold_pkg::ASCII_LIMIT)
                begin
                    lst[n] = b;
                    n      = n + 3'd1;
                end
                else if ((b >= ufold_pkg::LEAD2_LO) && (b <= ufold_pkg::LEAD2_HI))
                begin
                    hb[0] = b;
                    hc    = 2'd1;
                    el    = 3'd2;
                end
                else if ((b >= ufold_pkg::LEAD3_LO) && (b <= ufold_pkg::LEAD3_HI))
                begin
                    hb[0] = b;
                    hc    = 2'd1;
                    el    = 3'd3;
                end
                else if ((b >= ufold_pkg::LEAD4_LO) && (b <= ufold_pkg::LEAD4_HI))
                begin
                    hb[0] = b;
                    hc    = 2'd1;
                    el    = 3'd4;
                end
                else
                begin
                    lst[n] = ufold_pkg::REPL_B0;
                    n      = n + 3'd1;
                    lst[n] = ufold_pkg::REPL_B1;
                    n      = n + 3'd1;
                    lst[n] = ufold_pkg::REPL_B2;
                    n      = n + 3'd1;
                end
            end

            // flush an unfinished sequence at word end
            if (item.word_end && (hc != 2'd0))
            begin
                lst[n] = ufold_pkg::REPL_B0;
                n      = n + 3'd1;
                lst[n] = ufold_pkg::REPL_B1;
                n      = n + 3'd1;
                lst[n] = ufold_pkg::REPL_B2;
                n      = n + 3'd1;
                hc     = 2'd0;
                el     = 3'd0;
            end
        end

        burst.bytes       = lst;
        burst.count       = n;
        burst.word_end    = item.word_end;
        held_next.bytes   = hb;
        held_next.count   = hc;
        held_next.exp_len = el;
    end

endmodule

// ===== hdl/ufold_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufold_out_buf
// Result register: holds one decoded burst and shifts it out one byte per
// accepted item, marking the last byte of the burst.
// ----------------------------------------------------------------------------
module ufold_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  ufold_pkg::burst_t    burst,
    output logic                 free,
    output logic                 norm_valid,
    input  logic                 norm_ready,
    output ufold_pkg::out_item_t norm_item
);

    logic [ufold_pkg::MAX_BURST-1:0][7:0] bytes_reg;
    logic [ufold_pkg::MAX_BURST-1:0][7:0] bytes_next;
    logic [2:0]                           rem_reg;
    logic [2:0]                           rem_next;
    logic                                 end_reg;
    logic                                 end_next;
    logic                                 last;
    logic                                 pop;

    assign last       = (rem_reg == 3'd1);
    assign norm_valid = (rem_reg != 3'd0);
    assign pop        = norm_valid && norm_ready;
    assign free       = (rem_reg == 3'd0) || (last && norm_ready);

    assign norm_item.out_byte     = bytes_reg[0];
    assign norm_item.run_end      = last;
    assign norm_item.out_word_end = last && end_reg;

    always_comb
    begin
        bytes_next = bytes_reg;
        rem_next   = rem_reg;
        end_next   = end_reg;
        priority if (load)
        begin
            bytes_next = burst.bytes;
            rem_next   = burst.count;
            end_next   = burst.word_end;
        end
        else if (pop)
        begin
            bytes_next = bytes_reg >> 8;
            rem_next   = rem_reg - 3'd1;
        end
        else
        begin
            rem_next = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
            end_reg <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            end_reg <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

// ===== hdl/utf8_accent_fold_stream_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_accent_fold_stream_core
// Path: an accepted item is registered in the input register, then decoded
// into the output register, which presents the first output byte.
// Throughput: 1 item per cycle while items yield at most one byte each and
// norm_ready is high; a burst of up to 6 bytes occupies the output register.
// Reset: asynchronous active low; clears held sequence, sets fold_enable to 1.
// ----------------------------------------------------------------------------
module utf8_accent_fold_stream_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    input  logic                 word_valid,
    output logic                 word_ready,
    input  ufold_pkg::in_item_t  word_item,
    output logic                 norm_valid,
    input  logic                 norm_ready,
    output ufold_pkg::out_item_t norm_item
);

    logic                                  fold_enable_reg;
    logic                                  in_vld_reg;
    logic                                  in_vld_next;
    ufold_pkg::in_item_t                   in_item_reg;
    logic [ufold_pkg::HELD_DEPTH-1:0][7:0] held_bytes_reg;
    logic [1:0]                            held_count_reg;
    logic [2:0]                            exp_len_reg;
    ufold_pkg::held_t                      held_cur;
    ufold_pkg::held_t                      held_upd;
    ufold_pkg::burst_t                     burst;
    logic                                  buf_free;
    logic                                  take;
    logic                                  cfg_wr;
    logic                                  in_acc;

    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign take       = in_vld_reg && buf_free;
    assign word_ready = !in_vld_reg || take;
    assign in_acc     = word_valid && word_ready;

    assign held_cur.bytes   = held_bytes_reg;
    assign held_cur.count   = held_count_reg;
    assign held_cur.exp_len = exp_len_reg;

    always_comb
    begin
        priority if (in_acc)
        begin
            in_vld_next = 1'b1;
        end
        else if (take)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
    end

    ufold_decode u_decode
    (
        .item        (in_item_reg),
        .fold_enable (fold_enable_reg),
        .held        (held_cur),
        .burst       (burst),
        .held_next   (held_upd)
    );

    ufold_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .burst      (burst),
        .free       (buf_free),
        .norm_valid (norm_valid),
        .norm_ready (norm_ready),
        .norm_item  (norm_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_enable_reg <= 1'b1;
            in_vld_reg      <= 1'b0;
            held_count_reg  <= 2'd0;
            exp_len_reg     <= 3'd0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (cfg_wr)
            begin
                // drop any partial sequence on a register write
                fold_enable_reg <= cfg_data;
                held_count_reg  <= 2'd0;
                exp_len_reg     <= 3'd0;
            end
            else if (take)
            begin
                held_count_reg <= held_upd.count;
                exp_len_reg    <= held_upd.exp_len;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_item_reg <= word_item;
        end
        if (take)
        begin
            held_bytes_reg <= held_upd.bytes;
        end
    end

    a_word_end_is_run_end : assert property (
        @(posedge clk) disable iff (!rst_n)
        (norm_valid && norm_item.out_word_end) |-> norm_item.run_end
    ) else $error("out_word_end without run_end");

    a_held_consistent : assert property (
        @(posedge clk) disable iff (!rst_n)
        (held_count_reg != 2'd0) |->
            (((exp_len_reg == 3'd2) || (exp_len_reg == 3'd3) || (exp_len_reg == 3'd4)) &&
             ({1'b0, held_count_reg} < exp_len_reg))
    ) else $error("held count inconsistent with expected length");

    a_bypass_holds_nothing : assert property (
        @(posedge clk) disable iff (!rst_n)
        !fold_enable_reg |-> (held_count_reg == 2'd0)
    ) else $error("partial sequence held while folding is off");

    a_word_end_flushes : assert property (
        @(posedge clk) disable iff (!rst_n)
        (take && in_item_reg.word_end) |=> (held_count_reg == 2'd0)
    ) else $error("partial sequence survived word end");

endmodule
